@@ rtl/bxa_pkg.sv @@
// Shared constants, payload types and sequencer states for the boxcar average block.
package bxa_pkg;

   localparam int SAMPLE_BITS        = 16;
   localparam int FRACTION_BITS      = 8;
   localparam int MEAN_BITS          = SAMPLE_BITS + FRACTION_BITS;
   localparam int CFG_BITS           = 5;
   localparam int MAX_WINDOW_DEFAULT = 16;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   frame_end;
   } req_payload_type;

   typedef struct packed {
      logic [MEAN_BITS-1:0] mean_value;
      logic                 final_output;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ACCUM,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

endpackage

@@ rtl/bxa_cell.sv @@
// One history cell: holds a single sample and passes it to the next cell on a shift.
module bxa_cell (
   input  logic                            clock,
   input  logic                            shift_en,
   input  logic [bxa_pkg::SAMPLE_BITS-1:0] d_in,
   output logic [bxa_pkg::SAMPLE_BITS-1:0] q_out
);
   import bxa_pkg::*;

   logic [SAMPLE_BITS-1:0] value_ff;
   logic [SAMPLE_BITS-1:0] value_in;

   assign value_in = shift_en ? d_in : value_ff;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign q_out = value_ff;

endmodule

@@ rtl/bxa_history.sv @@
// Row of history cells, newest sample in cell zero, with one selectable read tap.
module bxa_history #(
   parameter int DEPTH = bxa_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                            clock,
   input  logic                            shift_en,
   input  logic [bxa_pkg::SAMPLE_BITS-1:0] sample_in,
   input  logic [$clog2(DEPTH)-1:0]        rd_index,
   output logic [bxa_pkg::SAMPLE_BITS-1:0] rd_data,
   output logic [bxa_pkg::SAMPLE_BITS-1:0] oldest
);
   import bxa_pkg::*;

   logic [SAMPLE_BITS-1:0] taps [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         bxa_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .d_in     (sample_in),
            .q_out    (taps[k])
         );
      end else begin : g_body
         bxa_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .d_in     (taps[k-1]),
            .q_out    (taps[k])
         );
      end
   end

   assign rd_data = taps[rd_index];
   assign oldest  = taps[DEPTH-1];

endmodule

@@ rtl/bxa_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module bxa_div #(
   parameter int NUM_W = 28,
   parameter int DEN_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             busy,
   output logic [NUM_W-1:0] quotient
);
   import bxa_pkg::*;

   localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic [DEN_W-1:0] rem_ff,  rem_in;
   logic [NUM_W-1:0] quo_ff,  quo_in;
   logic [DEN_W-1:0] den_ff,  den_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic             busy_ff, busy_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/boxcar_average_edge_clamped.sv @@
// Edge-clamped centered boxcar average over a spectrum frame. Each accepted sample
// shifts into a row of MAX_WINDOW history cells, and the sequencer then produces every
// output that the sample makes due. For a width W (0 and 1 both act as 1), output i is
// the floor of the sum of W samples, centered on i, times 2^FRACTION_BITS over W;
// positions before the frame start read the first sample and positions past the end
// read the last one. Outputs trail the input by ceil(W/2)-1 samples, and the sample
// flagged frame_end flushes the rest, the last output carrying final_output. An input
// transfer is followed by a check of what is due; each output that it makes due then takes
// a pass that adds up the window one cell per cycle, a run of the bit-serial divider, one
// step per quotient bit, until it reports done, and a load of the output register, which
// waits while a previous output is held by rsp_stall, before the next check. Inputs are
// taken one at a time, but the next input transfer may occur while the last output still
// waits in the output register. The width register is written through the csr port,
// always ready, and is to be changed only while the block is idle; values above
// MAX_WINDOW are stored as MAX_WINDOW.
module boxcar_average_edge_clamped #(
   parameter int MAX_WINDOW = bxa_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bxa_pkg::req_payload_type     req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bxa_pkg::rsp_payload_type     rsp_payload,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bxa_pkg::CFG_BITS-1:0] csr_wdata
);
   import bxa_pkg::*;

   // Counts and widths up to MAX_WINDOW, signed window offsets, cell index, sums.
   localparam int CW    = $clog2(MAX_WINDOW + 1);
   localparam int BK_W  = CW + 2;
   localparam int IDX_W = $clog2(MAX_WINDOW);
   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int DIV_W = SUM_W + FRACTION_BITS;

   state_type state_ff, state_in;

   logic [CW-1:0]          width_ff,  width_in;
   logic [CW-1:0]          lag_ff,    lag_in;
   logic [CW-1:0]          seen_ff,   seen_in;
   logic [CW-1:0]          tap_ff,    tap_in;
   logic [SAMPLE_BITS-1:0] first_ff,  first_in;
   logic                   last_ff,   last_in;
   logic [SUM_W-1:0]       sum_ff,    sum_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff,  rsp_data_in;

   logic                   shift_en;
   logic                   div_start;
   logic                   div_busy;
   logic [DIV_W-1:0]       div_dividend;
   logic [DIV_W-1:0]       div_quotient;

   logic [CW-1:0]          w_eff;
   logic [CW-1:0]          half;
   logic [CW-1:0]          lag_limit;
   logic [CW-1:0]          ago;
   logic signed [BK_W-1:0] back;
   logic [BK_W-1:0]        back_pos;
   logic                   beyond;
   logic [SAMPLE_BITS-1:0] hist_data;
   logic [SAMPLE_BITS-1:0] hist_oldest;
   logic [SAMPLE_BITS-1:0] tap_sample;
   logic [SUM_W-1:0]       sum_next;

   // The width register accepts a write in every cycle.
   assign csr_ready = 1'b1;

   always_comb begin
      width_in = width_ff;
      if (csr_valid && csr_ready) begin
         if (32'(csr_wdata) > 32'(MAX_WINDOW)) begin
            width_in = CW'(MAX_WINDOW);
         end else begin
            width_in = CW'(csr_wdata);
         end
      end
   end

   // Effective width, half width and the number of outputs that may stay pending.
   assign w_eff     = (width_ff < CW'(2)) ? CW'(1) : width_ff;
   assign half      = w_eff >> 1;
   assign lag_limit = w_eff - CW'(1) - half;

   // Offset, counted back from the newest sample, of the window tap read this cycle.
   // Offsets before the newest clamp to it; offsets past the stored frame read the first
   // sample while the frame is short and the oldest cell once the row is full.
   assign ago      = lag_ff - CW'(1);
   assign back     = $signed({2'b00, ago}) + $signed({2'b00, half})
                     - $signed({2'b00, tap_ff});
   assign back_pos = back[BK_W-1] ? '0 : back;
   assign beyond   = back_pos >= {2'b00, seen_ff};

   always_comb begin
      if (!beyond) begin
         tap_sample = hist_data;
      end else if (seen_ff < CW'(MAX_WINDOW)) begin
         tap_sample = first_ff;
      end else begin
         tap_sample = hist_oldest;
      end
   end

   assign sum_next     = sum_ff + SUM_W'(tap_sample);
   assign div_dividend = DIV_W'(sum_next) << FRACTION_BITS;

   bxa_history #(
      .DEPTH (MAX_WINDOW)
   ) u_history (
      .clock     (clock),
      .shift_en  (shift_en),
      .sample_in (req_payload.sample),
      .rd_index  (back_pos[IDX_W-1:0]),
      .rd_data   (hist_data),
      .oldest    (hist_oldest)
   );

   bxa_div #(
      .NUM_W (DIV_W),
      .DEN_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (w_eff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   // Sequencer: take a sample, then emit every output it makes due, one at a time.
   always_comb begin
      state_in     = state_ff;
      lag_in       = lag_ff;
      seen_in      = seen_ff;
      tap_in       = tap_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      req_stall    = 1'b1;
      shift_en     = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // The input is never stalled here, so a valid sample is a transfer.
            req_stall = 1'b0;
            if (req_valid) begin
               shift_en = 1'b1;
               if (seen_ff == '0) begin
                  first_in = req_payload.sample;
               end
               if (seen_ff < CW'(MAX_WINDOW)) begin
                  seen_in = seen_ff + CW'(1);
               end
               lag_in   = lag_ff + CW'(1);
               last_in  = req_payload.frame_end;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((lag_ff > lag_limit) || (last_ff && (lag_ff != '0))) begin
               sum_in   = '0;
               tap_in   = '0;
               state_in = ST_ACCUM;
            end else begin
               // The frame has been flushed completely when the last sample was taken.
               if (last_ff) begin
                  seen_in  = '0;
                  lag_in   = '0;
                  first_in = '0;
                  last_in  = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_ACCUM: begin
            sum_in = sum_next;
            tap_in = tap_ff + CW'(1);
            if (tap_ff == w_eff - CW'(1)) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.mean_value   = div_quotient[MEAN_BITS-1:0];
               rsp_data_in.final_output = last_ff && (lag_ff == CW'(1));
               lag_in                   = lag_ff - CW'(1);
               state_in                 = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= '0;
         lag_ff       <= '0;
         seen_ff      <= '0;
         first_ff     <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         lag_ff       <= lag_in;
         seen_ff      <= seen_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tap_ff      <= tap_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

@@ bench/boxcar_average_edge_clamped_tb.sv @@
// Self-checking testbench for the edge-clamped boxcar average, driven with random flow control.
`timescale 1ns / 100ps

module boxcar_average_edge_clamped_tb;
   import bxa_pkg::*;

   localparam int MAX_WIN        = MAX_WINDOW_DEFAULT;
   localparam int SETTLE_CYCLES  = 40;    // covers an item that makes no output plus the output register
   localparam int HOLD_CYCLES    = 400;   // the one long hold-off of the receiver
   localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transfer before the run is abandoned
   localparam int RANDOM_ITEMS   = 420;
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   req_payload_type     req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   rsp_payload_type     rsp_payload;
   logic                csr_valid   = 1'b0;
   logic                csr_ready;
   logic [CFG_BITS-1:0] csr_wdata   = '0;

   // Samples waiting for the driver, and the smoothed outputs the block still owes us.
   req_payload_type queued_samples [$];
   rsp_payload_type pending_means [$];

   // Shadow state of the filter, kept up to date by the monitor.
   logic [SAMPLE_BITS-1:0] sample_history [MAX_WIN];
   logic [SAMPLE_BITS-1:0] frame_first;
   int unsigned            frame_seen;
   int unsigned            lag_pending;
   int unsigned            width_setting;

   int unsigned    mismatch_count;
   int unsigned    idle_cycles;
   int unsigned    gap_left;
   int unsigned    burst_left;
   int unsigned    hold_left;
   int unsigned    seg_left;
   stall_mode_type stall_mode;
   logic           stall_next;
   logic           hold_wanted = 1'b0;
   logic           hold_done;

   boxcar_average_edge_clamped i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Sample at a distance 'back' behind the newest one, clamped to the frame start.
   // Once the history has filled up, anything older reads the oldest stored sample.
   function automatic logic [SAMPLE_BITS-1:0] history_tap(int back);
      if (back < 0) back = 0;
      if (back >= int'(frame_seen)) begin
         return (frame_seen < MAX_WIN) ? frame_first : sample_history[MAX_WIN-1];
      end
      return sample_history[back];
   endfunction

   // Mean of the output that lies 'ago' samples before the newest one, 8 fraction bits.
   function automatic logic [MEAN_BITS-1:0] boxcar_mean(int ago);
      int          w;
      int          half;
      logic [63:0] total;
      w     = (width_setting < 2) ? 1 : int'(width_setting);
      half  = w / 2;
      total = '0;
      for (int j = 0; j < w; j++) total += history_tap(ago + half - j);
      return MEAN_BITS'((total << FRACTION_BITS) / 64'(w));
   endfunction

   // Shift one accepted sample into the shadow state and queue every output it releases.
   // A frame end drains everything still pending and flags the very last output.
   function automatic void smooth_sample(req_payload_type item);
      int unsigned     w;
      int unsigned     lag_limit;
      rsp_payload_type due;
      w         = (width_setting < 2) ? 1 : width_setting;
      lag_limit = w - 1 - w / 2;
      for (int i = MAX_WIN - 1; i > 0; i--) sample_history[i] = sample_history[i-1];
      sample_history[0] = item.sample;
      if (frame_seen == 0) frame_first = item.sample;
      if (frame_seen < MAX_WIN) frame_seen++;
      lag_pending++;
      while (lag_pending > lag_limit || (item.frame_end && lag_pending > 0)) begin
         due.mean_value   = boxcar_mean(int'(lag_pending) - 1);
         due.final_output = item.frame_end && (lag_pending == 1);
         pending_means.push_back(due);
         lag_pending--;
      end
      if (item.frame_end) begin
         frame_seen  = 0;
         lag_pending = 0;
         frame_first = '0;
      end
   endfunction

   // Monitor: tracks every transfer on all three channels at the clock edge. Inputs are
   // handled before outputs so the store of owed means is always current when compared.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         for (int i = 0; i < MAX_WIN; i++) sample_history[i] = '0;
         frame_first   = '0;
         frame_seen    = 0;
         lag_pending   = 0;
         width_setting = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            width_setting = (csr_wdata > MAX_WIN) ? MAX_WIN : csr_wdata;
         end
         if (req_valid && !req_stall) smooth_sample(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (pending_means.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Unexpected output: mean %h final %b",
                           rsp_payload.mean_value, rsp_payload.final_output);
               end
            end else begin
               want = pending_means.pop_front();
               if (rsp_payload.mean_value !== want.mean_value ||
                   rsp_payload.final_output !== want.final_output) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("Mismatch: expected mean %h final %b, got mean %h final %b",
                              want.mean_value, want.final_output,
                              rsp_payload.mean_value, rsp_payload.final_output);
                  end
               end
            end
         end
      end
   end

   // Driver: offers queued samples in bursts of random length separated by random gaps.
   // A stalled transfer keeps its payload; a new one is only loaded once the slot is free.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         gap_left   = 0;
         burst_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0 || queued_samples.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            req_payload <= queued_samples.pop_front();
            req_valid   <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: gap_left = 0;
                  5, 6, 7:       gap_left = $urandom_range(1, 4);
                  default:       gap_left = $urandom_range(5, 40);
               endcase
            end
         end
      end
   end

   // Receiver: stalls on a pattern that changes mode every so often, and once holds
   // the output off for a long stretch so the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_left  = 0;
         hold_done  = 1'b0;
         seg_left   = 0;
         stall_mode = STALL_NONE;
      end else begin
         if (hold_wanted && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (seg_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            seg_left   = $urandom_range(16, 160);
         end else begin
            seg_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            case (stall_mode)
               STALL_NONE:  stall_next = 1'b0;
               STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
               STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
               default:     stall_next = ~rsp_stall;
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // Watchdog: any cycle with a transfer on some channel restarts the count.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic void queue_sample(logic [SAMPLE_BITS-1:0] value, logic last);
      req_payload_type item;
      item.sample    = value;
      item.frame_end = last;
      queued_samples.push_back(item);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return SAMPLE_BITS'($urandom_range(0, 15));
         3:       return SAMPLE_BITS'($urandom_range(16'hFFF0, 16'hFFFF));
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // Waits until every queued sample has gone in and every owed output has come out,
   // then lets the block finish any item that released nothing.
   task automatic settle();
      while (queued_samples.size() != 0 || req_valid || pending_means.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // The width register may only change while the block is idle.
   task automatic write_width(logic [CFG_BITS-1:0] value);
      settle();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int unsigned random_count;
      int unsigned phase_count;
      int unsigned phase_target;
      int unsigned phase_items;
      int unsigned frame_len;
      logic [CFG_BITS-1:0] width_pick;

      mismatch_count = 0;
      idle_cycles    = 0;
      random_count   = 0;
      phase_count    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Width 0 passes samples through, including the extremes.
      write_width(5'd0);
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'hAAAA, 1'b1);
      // Width 1 behaves the same way.
      write_width(5'd1);
      queue_sample(16'h5555, 1'b0);
      queue_sample(16'h1234, 1'b1);
      // Full width: a one-sample frame flushes its single output, then an alternating frame.
      write_width(5'd16);
      queue_sample(16'hFFFF, 1'b1);
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'hFFFF, 1'b1);
      // Smallest real window, then an odd one.
      write_width(5'd2);
      queue_sample(16'h0001, 1'b0);
      queue_sample(16'h0002, 1'b0);
      queue_sample(16'h0003, 1'b1);
      write_width(5'd3);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'h8001, 1'b1);
      // A register value above the maximum is stored as the maximum.
      write_width(5'd31);
      queue_sample(16'h7FFF, 1'b0);
      queue_sample(16'h0100, 1'b1);
      // The width changes in the middle of a frame.
      write_width(5'd5);
      queue_sample(16'h0010, 1'b0);
      queue_sample(16'h0020, 1'b0);
      queue_sample(16'h0030, 1'b0);
      queue_sample(16'h0040, 1'b0);
      write_width(5'd2);
      queue_sample(16'h0050, 1'b0);
      queue_sample(16'h0060, 1'b1);

      // Random phases: the first few widths are fixed extremes, the rest are random.
      // Each phase is made of complete frames, sometimes followed by an open one
      // that the next width takes over.
      while (random_count < RANDOM_ITEMS) begin
         case (phase_count)
            0:       width_pick = 5'd16;
            1:       width_pick = 5'd0;
            2:       width_pick = 5'd17;
            3:       width_pick = 5'd1;
            4:       width_pick = 5'd31;
            5:       width_pick = 5'd2;
            default: width_pick = CFG_BITS'($urandom_range(0, 31));
         endcase
         write_width(width_pick);
         phase_target = $urandom_range(25, 60);
         phase_items  = 0;
         while (phase_items < phase_target) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: frame_len = $urandom_range(1, 8);
               7, 8:                frame_len = $urandom_range(9, 20);
               default:             frame_len = $urandom_range(21, 40);
            endcase
            for (int k = 0; k < int'(frame_len); k++) begin
               queue_sample(pick_sample(), k == int'(frame_len) - 1);
            end
            phase_items += frame_len;
         end
         if ($urandom_range(0, 3) == 0) begin
            frame_len = $urandom_range(1, 6);
            for (int k = 0; k < int'(frame_len); k++) queue_sample(pick_sample(), 1'b0);
            phase_items += frame_len;
         end
         // The full-width phase is slow, so it is where the long hold-off goes.
         if (phase_count == 0) hold_wanted = 1'b1;
         random_count += phase_items;
         phase_count++;
      end

      settle();
      if (mismatch_count == 0 && pending_means.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
